/* hw/rtl/jkve_pkg.sv */
package jkve_pkg;

    localparam int KEY_MAX    = 16;
    localparam int DEPTH_BITS = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [1:0] REG_KEY_HIGH = 2'd1;
    localparam logic [1:0] REG_KEY_LEN  = 2'd2;

    localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    typedef enum logic [3:0] {
        PH_SCAN, PH_KEY, PH_COLON, PH_SPACE, PH_VSTR,
        PH_VOBJ, PH_VARR, PH_VPLAIN, PH_DONE
    } phase_t;

    // Classified byte handed from the front to the back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       eod;
        logic       is_quote;
        logic       is_colon;
        logic       is_space;
        logic       is_term;
        logic       is_sign;
        logic       is_digit;
    } cls_t;

    typedef struct packed {
        logic        value_valid;
        logic [7:0]  value_byte;
        logic        value_end;
        logic        value_closed;
        logic signed [31:0] int_value;
        logic        document_done;
        logic        key_found;
        logic        depth_overflow;
    } res_t;

endpackage

/* hw/rtl/jkve_if.sv */
interface jkve_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_document;
    modport source (output valid, data_byte, end_of_document, input ready);
    modport sink (input valid, data_byte, end_of_document, output ready);
endinterface

interface jkve_out_if;
    logic        valid;
    logic        ready;
    logic        value_valid;
    logic [7:0]  value_byte;
    logic        value_end;
    logic        value_closed;
    logic signed [31:0] int_value;
    logic        document_done;
    logic        key_found;
    logic        depth_overflow;
    modport source (output valid, value_valid, value_byte, value_end, value_closed,
                    int_value, document_done, key_found, depth_overflow, input ready);
    modport sink (input valid, value_valid, value_byte, value_end, value_closed,
                  int_value, document_done, key_found, depth_overflow, output ready);
endinterface

interface jkve_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/jkve_front.sv */
module jkve_front (
    jkve_in_if.sink         in_ch,
    output logic            q_push,
    output jkve_pkg::cls_t  q_word,
    input  logic            q_full
);

    logic [7:0] b;

    assign b = in_ch.data_byte;
    assign in_ch.ready = !q_full;
    assign q_push = in_ch.valid && !q_full;

    // Classify the byte; a zero byte also ends the document.
    always_comb
    begin
        q_word.data_byte = b;
        q_word.eod       = in_ch.end_of_document || (b == 8'd0);
        q_word.is_quote  = (b == jkve_pkg::CH_QUOTE);
        q_word.is_colon  = (b == jkve_pkg::CH_COLON);
        q_word.is_space  = (b == jkve_pkg::CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
        q_word.is_term   = (b == jkve_pkg::CH_COMMA) || (b == jkve_pkg::CH_RBRACE);
        q_word.is_sign   = (b == jkve_pkg::CH_MINUS) || (b == jkve_pkg::CH_PLUS);
        q_word.is_digit  = (b >= jkve_pkg::CH_ZERO) && (b <= jkve_pkg::CH_NINE);
    end

endmodule

/* hw/rtl/jkve_queue.sv */
module jkve_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jkve_pkg::cls_t  push_word,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output jkve_pkg::cls_t  pop_word
);

    jkve_pkg::cls_t mem_reg [jkve_pkg::QUEUE_DEPTH];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'(jkve_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign pop_word  = mem_reg[rd_ptr_reg];

    // Two-entry circular queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

endmodule

/* hw/rtl/jkve_back.sv */
module jkve_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  jkve_pkg::cls_t  q_word,
    output logic            q_pop,
    jkve_cfg_if.sink        cfg,
    jkve_out_if.source      out_ch
);

    localparam int DB = jkve_pkg::DEPTH_BITS;

    jkve_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  mpos_reg, mpos_next;
    logic        mfail_reg, mfail_next;
    logic [DB-1:0] depth_reg, depth_next;
    logic [31:0] acc_reg, acc_next;
    logic        neg_reg, neg_next, act_reg, act_next;
    logic        found_reg, found_next, ovf_reg, ovf_next;
    logic [63:0] key_low_reg, key_high_reg;
    logic [4:0]  key_len_reg;

    logic        ovalid_reg;
    jkve_pkg::res_t res_reg, res_next;

    logic        step;
    logic [7:0]  b;
    logic [7:0]  kchar;
    logic [35:0] prod;
    logic [31:0] ires;
    logic        nz;

    assign cfg.ready = 1'b1;
    assign q_pop = q_valid && (!ovalid_reg || out_ch.ready);
    assign step  = q_pop;
    assign b     = q_word.data_byte;
    assign nz    = (b != 8'd0);

    assign kchar = mpos_reg[3] ? key_high_reg[{mpos_reg[2:0], 3'b000} +: 8]
                               : key_low_reg[{mpos_reg[2:0], 3'b000} +: 8];
    assign prod  = 36'({acc_reg, 3'b000}) + 36'({acc_reg, 1'b0})
                   + 36'(b - jkve_pkg::CH_ZERO);

    // Key registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            key_len_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                jkve_pkg::REG_KEY_LOW:  key_low_reg  <= cfg.data;
                jkve_pkg::REG_KEY_HIGH: key_high_reg <= cfg.data;
                jkve_pkg::REG_KEY_LEN:  key_len_reg  <= cfg.data[4:0];
                default: ;
            endcase
        end
    end

    // Parser state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= jkve_pkg::PH_SCAN;
            mpos_reg   <= '0;
            mfail_reg  <= 1'b0;
            depth_reg  <= '0;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            act_reg    <= 1'b0;
            found_reg  <= 1'b0;
            ovf_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg <= phase_next;
                mpos_reg  <= mpos_next;
                mfail_reg <= mfail_next;
                depth_reg <= depth_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                act_reg   <= act_next;
                found_reg <= found_next;
                ovf_reg   <= ovf_next;
            end
            if (step)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
            res_reg <= res_next;
    end

    // Next state for one byte.
    always_comb
    begin
        logic first_int;
        logic feed_int;
        logic fin;
        logic fin_closed;
        logic up;
        logic emit;
        logic [31:0] acc_v;
        logic neg_v;
        logic act_v;
        logic [DB-1:0] depth_v;
        logic ovf_v;
        first_int  = 1'b0;
        feed_int   = 1'b0;
        fin        = 1'b0;
        fin_closed = 1'b0;
        up         = 1'b0;
        emit       = 1'b0;
        phase_next = phase_reg;
        mpos_next  = mpos_reg;
        mfail_next = mfail_reg;
        depth_v    = depth_reg;
        found_next = found_reg;
        if (nz)
        begin
            unique case (phase_reg)
                jkve_pkg::PH_SCAN:
                    if (q_word.is_quote)
                    begin
                        phase_next = jkve_pkg::PH_KEY;
                        mpos_next  = '0;
                        mfail_next = 1'b0;
                    end
                jkve_pkg::PH_KEY:
                    if (q_word.is_quote)
                    begin
                        if (!mfail_reg && mpos_reg == key_len_reg)
                        begin
                            found_next = 1'b1;
                            phase_next = jkve_pkg::PH_COLON;
                        end
                        else
                            phase_next = jkve_pkg::PH_SCAN;
                    end
                    else if (!mfail_reg)
                    begin
                        if (mpos_reg >= key_len_reg || mpos_reg >= 5'(jkve_pkg::KEY_MAX)
                            || b != kchar)
                            mfail_next = 1'b1;
                        else
                            mpos_next = mpos_reg + 5'd1;
                    end
                jkve_pkg::PH_COLON:
                    if (q_word.is_colon)
                        phase_next = jkve_pkg::PH_SPACE;
                jkve_pkg::PH_SPACE:
                    if (!q_word.is_space)
                    begin
                        first_int = 1'b1;
                        if (q_word.is_quote)
                            phase_next = jkve_pkg::PH_VSTR;
                        else if (b == jkve_pkg::CH_LBRACE || b == jkve_pkg::CH_LBRACK)
                        begin
                            depth_v = '0;
                            up = 1'b1;
                            emit = 1'b1;
                            phase_next = (b == jkve_pkg::CH_LBRACE) ? jkve_pkg::PH_VOBJ
                                                                    : jkve_pkg::PH_VARR;
                        end
                        else if (q_word.is_term)
                        begin
                            fin = 1'b1;
                            fin_closed = 1'b1;
                        end
                        else
                        begin
                            phase_next = jkve_pkg::PH_VPLAIN;
                            emit = 1'b1;
                        end
                    end
                jkve_pkg::PH_VSTR:
                begin
                    feed_int = 1'b1;
                    if (q_word.is_quote)
                    begin
                        fin = 1'b1;
                        fin_closed = 1'b1;
                    end
                    else
                        emit = 1'b1;
                end
                jkve_pkg::PH_VOBJ, jkve_pkg::PH_VARR:
                begin
                    feed_int = 1'b1;
                    emit = 1'b1;
                    if ((phase_reg == jkve_pkg::PH_VOBJ && b == jkve_pkg::CH_LBRACE) ||
                        (phase_reg == jkve_pkg::PH_VARR && b == jkve_pkg::CH_LBRACK))
                        up = 1'b1;
                    else if ((phase_reg == jkve_pkg::PH_VOBJ && b == jkve_pkg::CH_RBRACE) ||
                             (phase_reg == jkve_pkg::PH_VARR && b == jkve_pkg::CH_RBRACK))
                    begin
                        if (depth_v != '0)
                            depth_v = depth_v - DB'(1);
                        if (depth_v == '0)
                        begin
                            fin = 1'b1;
                            fin_closed = 1'b1;
                        end
                    end
                end
                jkve_pkg::PH_VPLAIN:
                    if (q_word.is_term)
                    begin
                        fin = 1'b1;
                        fin_closed = 1'b1;
                    end
                    else
                    begin
                        feed_int = 1'b1;
                        emit = 1'b1;
                    end
                jkve_pkg::PH_DONE: ;
                default: ;
            endcase
        end

        // Depth count with saturation.
        ovf_v = ovf_reg;
        if (up)
        begin
            if (depth_v >= jkve_pkg::DEPTH_MAX)
                ovf_v = 1'b1;
            else
                depth_v = depth_v + DB'(1);
        end

        // Integer reader: a leading sign or digit opens it, digits accumulate with saturation.
        acc_v = acc_reg;
        neg_v = neg_reg;
        act_v = act_reg;
        if (first_int)
        begin
            acc_v = '0;
            neg_v = (b == jkve_pkg::CH_MINUS);
            act_v = 1'b1;
            if (q_word.is_digit)
                acc_v = 32'(b - jkve_pkg::CH_ZERO);
            else if (!q_word.is_sign)
                act_v = 1'b0;
        end
        else if (feed_int && act_reg)
        begin
            if (q_word.is_digit)
                acc_v = (prod > 36'(jkve_pkg::MAG_LIMIT)) ? jkve_pkg::MAG_LIMIT : prod[31:0];
            else
                act_v = 1'b0;
        end

        if (q_word.eod && phase_reg != jkve_pkg::PH_SCAN && phase_reg != jkve_pkg::PH_KEY
            && phase_next != jkve_pkg::PH_DONE && phase_next != jkve_pkg::PH_SCAN
            && phase_next != jkve_pkg::PH_KEY)
            fin = 1'b1;
        else if (q_word.eod && !fin && (phase_next == jkve_pkg::PH_COLON))
            fin = 1'b1;
        if (fin)
            phase_next = jkve_pkg::PH_DONE;

        ires = neg_v ? (32'd0 - acc_v) : ((acc_v > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc_v);

        res_next.value_valid    = emit;
        res_next.value_byte     = emit ? b : 8'd0;
        res_next.value_end      = fin;
        res_next.value_closed   = fin && fin_closed;
        res_next.int_value      = fin ? $signed(ires) : 32'sd0;
        res_next.document_done  = q_word.eod;
        res_next.key_found      = q_word.eod && found_next;
        res_next.depth_overflow = ovf_v;

        // Document end returns the parser to its reset state.
        if (q_word.eod)
        begin
            phase_next = jkve_pkg::PH_SCAN;
            mpos_next  = '0;
            mfail_next = 1'b0;
            depth_v    = '0;
            acc_v      = '0;
            neg_v      = 1'b0;
            act_v      = 1'b0;
            found_next = 1'b0;
            ovf_v      = 1'b0;
        end
        depth_next = depth_v;
        acc_next   = acc_v;
        neg_next   = neg_v;
        act_next   = act_v;
        ovf_next   = ovf_v;
    end

    assign out_ch.valid          = ovalid_reg;
    assign out_ch.value_valid    = res_reg.value_valid;
    assign out_ch.value_byte     = res_reg.value_byte;
    assign out_ch.value_end      = res_reg.value_end;
    assign out_ch.value_closed   = res_reg.value_closed;
    assign out_ch.int_value      = res_reg.int_value;
    assign out_ch.document_done  = res_reg.document_done;
    assign out_ch.key_found      = res_reg.key_found;
    assign out_ch.depth_overflow = res_reg.depth_overflow;

endmodule

/* hw/rtl/json_key_value_extractor_top.sv */
// JSON key/value extractor.
// Channels: in_ch takes one document byte per word (data_byte, end_of_document);
// out_ch gives exactly one result word per input word; cfg writes the key
// registers (index 0 low key bytes, 1 high key bytes, 2 key length).
// Throughput is one byte per cycle while the receiver takes result words: the front
// classifies a byte as it is taken, a two-word queue holds it, and the back updates
// the parser state and its ten-times integer accumulator for each byte.
// An accepted byte is written into the queue, and the back then registers its
// result word in the output register.
// When the receiver stalls the output register holds its word, the queue
// fills, and in_ch.ready drops after two more words.
// Reset clears the parser to scanning, the key registers to zero and empties
// the queue and output register. Configuration writes are always ready; the user must
// make them only while the block is idle, as the block itself does not enforce it.
module json_key_value_extractor_top (
    input  logic        clk,
    input  logic        rst_n,
    jkve_in_if.sink     in_ch,
    jkve_out_if.source  out_ch,
    jkve_cfg_if.sink    cfg
);

    logic           q_push, q_full, q_pop, q_ne;
    jkve_pkg::cls_t q_in, q_out;

    jkve_front u_front (
        .in_ch(in_ch),
        .q_push(q_push), .q_word(q_in), .q_full(q_full)
    );

    jkve_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_word(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_ne), .pop_word(q_out)
    );

    jkve_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_word(q_out), .q_pop(q_pop),
        .cfg(cfg), .out_ch(out_ch)
    );

endmodule

/* hw/rtl/jkve_checker.sv */
module jkve_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic value_end,
    input logic value_closed,
    input logic document_done,
    input logic key_found
);

    // A stalled result word stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // A closed value flag only comes with a value end.
    a_closed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_closed |-> value_end)
        else $error("value_closed without value_end");

    // The found flag is reported only at document end.
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_found |-> document_done)
        else $error("key_found outside document end");

    // An unterminated value end coincides with document end.
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && value_end && !value_closed |-> document_done)
        else $error("open value end away from document end");

endmodule

bind json_key_value_extractor_top jkve_checker u_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .value_end(out_ch.value_end),
    .value_closed(out_ch.value_closed), .document_done(out_ch.document_done),
    .key_found(out_ch.key_found)
);

/* sim/tb_if_note.sv */
package tb_doc_pkg;

    // Expected result word of the extractor, one per document byte.
    typedef struct packed {
        logic        value_valid;
        logic [7:0]  value_byte;
        logic        value_end;
        logic        value_closed;
        logic [31:0] int_value;
        logic        document_done;
        logic        key_found;
        logic        depth_overflow;
    } extract_word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_document;
    } doc_byte_t;

endpackage

/* sim/tb.sv */
module tb;

    logic clk;
    logic rst_n;

    jkve_in_if  in_ch ();
    jkve_out_if out_ch ();
    jkve_cfg_if cfg ();

    json_key_value_extractor_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // Predictor copy of the key registers and parser state.
    logic [63:0] key_lo_m, key_hi_m;
    logic [4:0]  key_len_m;
    jkve_pkg::phase_t ph_m;
    logic [4:0]  mpos_m;
    logic        mfail_m;
    logic [jkve_pkg::DEPTH_BITS-1:0] depth_m;
    logic [31:0] acc_m;
    logic        neg_m, iact_m, found_m, ovf_m;

    tb_doc_pkg::doc_byte_t     pending_bytes[$];
    tb_doc_pkg::extract_word_t expected_words[$];
    int errors = 0;
    int words_checked = 0;
    int docs_seen = 0;
    int values_seen = 0;
    longint cycle_count = 0;
    logic   hold_req = 1'b0;
    logic   hold_started = 1'b0;
    int     hold_off = 0;

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_document();
        ph_m = jkve_pkg::PH_SCAN;
        mpos_m = '0;
        mfail_m = 1'b0;
        depth_m = '0;
        acc_m = '0;
        neg_m = 1'b0;
        iact_m = 1'b0;
        found_m = 1'b0;
        ovf_m = 1'b0;
    endfunction

    function automatic logic [7:0] key_char_at(logic [4:0] pos);
        logic [63:0] w;
        w = (pos < 8) ? key_lo_m : key_hi_m;
        return w[pos[2:0]*8 +: 8];
    endfunction

    function automatic void integer_step(logic [7:0] b, bit first);
        logic [63:0] t;
        if (first)
        begin
            acc_m = '0;
            neg_m = (b == jkve_pkg::CH_MINUS);
            iact_m = 1'b1;
            if (b == jkve_pkg::CH_MINUS || b == jkve_pkg::CH_PLUS)
                return;
        end
        if (!iact_m)
            return;
        if (b >= jkve_pkg::CH_ZERO && b <= jkve_pkg::CH_NINE)
        begin
            t = 64'(acc_m) * 10 + 64'(b - jkve_pkg::CH_ZERO);
            acc_m = (t > 64'(jkve_pkg::MAG_LIMIT)) ? jkve_pkg::MAG_LIMIT : t[31:0];
        end
        else
            iact_m = 1'b0;
    endfunction

    function automatic void close_value(ref tb_doc_pkg::extract_word_t w,
                                        input logic closed);
        w.value_end = 1'b1;
        w.value_closed = closed;
        if (neg_m)
            w.int_value = 32'd0 - acc_m;
        else
            w.int_value = (acc_m > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc_m;
        ph_m = jkve_pkg::PH_DONE;
    endfunction

    function automatic void nest_open();
        if (depth_m == jkve_pkg::DEPTH_MAX)
            ovf_m = 1'b1;
        else
            depth_m = depth_m + 1'b1;
    endfunction

    // Works out the result word caused by one document byte.
    function automatic tb_doc_pkg::extract_word_t extract_predict(tb_doc_pkg::doc_byte_t d);
        tb_doc_pkg::extract_word_t w;
        logic [7:0] b;
        logic eod;
        logic [7:0] opn, cls;
        w = '0;
        b = d.data_byte;
        eod = d.end_of_document || (b == 8'd0);
        if (b != 8'd0)
        begin
            case (ph_m)
                jkve_pkg::PH_SCAN:
                    if (b == jkve_pkg::CH_QUOTE)
                    begin
                        ph_m = jkve_pkg::PH_KEY;
                        mpos_m = '0;
                        mfail_m = 1'b0;
                    end
                jkve_pkg::PH_KEY:
                    if (b == jkve_pkg::CH_QUOTE)
                    begin
                        if (!mfail_m && mpos_m == key_len_m)
                        begin
                            found_m = 1'b1;
                            ph_m = jkve_pkg::PH_COLON;
                        end
                        else
                            ph_m = jkve_pkg::PH_SCAN;
                    end
                    else if (!mfail_m)
                    begin
                        if (mpos_m >= key_len_m || mpos_m >= jkve_pkg::KEY_MAX
                            || b != key_char_at(mpos_m))
                            mfail_m = 1'b1;
                        else
                            mpos_m = mpos_m + 1'b1;
                    end
                jkve_pkg::PH_COLON:
                    if (b == jkve_pkg::CH_COLON)
                        ph_m = jkve_pkg::PH_SPACE;
                jkve_pkg::PH_SPACE:
                    if (!(b == jkve_pkg::CH_SPACE || (b >= 8'd9 && b <= 8'd13)))
                    begin
                        integer_step(b, 1'b1);
                        if (b == jkve_pkg::CH_QUOTE)
                            ph_m = jkve_pkg::PH_VSTR;
                        else if (b == jkve_pkg::CH_LBRACE || b == jkve_pkg::CH_LBRACK)
                        begin
                            depth_m = '0;
                            nest_open();
                            ph_m = (b == jkve_pkg::CH_LBRACE) ? jkve_pkg::PH_VOBJ
                                                              : jkve_pkg::PH_VARR;
                            w.value_valid = 1'b1;
                            w.value_byte = b;
                        end
                        else if (b == jkve_pkg::CH_COMMA || b == jkve_pkg::CH_RBRACE)
                            close_value(w, 1'b1);
                        else
                        begin
                            ph_m = jkve_pkg::PH_VPLAIN;
                            w.value_valid = 1'b1;
                            w.value_byte = b;
                        end
                    end
                jkve_pkg::PH_VSTR:
                begin
                    integer_step(b, 1'b0);
                    if (b == jkve_pkg::CH_QUOTE)
                        close_value(w, 1'b1);
                    else
                    begin
                        w.value_valid = 1'b1;
                        w.value_byte = b;
                    end
                end
                jkve_pkg::PH_VOBJ, jkve_pkg::PH_VARR:
                begin
                    opn = (ph_m == jkve_pkg::PH_VOBJ) ? jkve_pkg::CH_LBRACE
                                                      : jkve_pkg::CH_LBRACK;
                    cls = (ph_m == jkve_pkg::PH_VOBJ) ? jkve_pkg::CH_RBRACE
                                                      : jkve_pkg::CH_RBRACK;
                    integer_step(b, 1'b0);
                    w.value_valid = 1'b1;
                    w.value_byte = b;
                    if (b == opn)
                        nest_open();
                    else if (b == cls)
                    begin
                        if (depth_m > 0)
                            depth_m = depth_m - 1'b1;
                        if (depth_m == 0)
                            close_value(w, 1'b1);
                    end
                end
                jkve_pkg::PH_VPLAIN:
                    if (b == jkve_pkg::CH_COMMA || b == jkve_pkg::CH_RBRACE)
                        close_value(w, 1'b1);
                    else
                    begin
                        integer_step(b, 1'b0);
                        w.value_valid = 1'b1;
                        w.value_byte = b;
                    end
                default: ;
            endcase
        end
        if (eod)
        begin
            if (ph_m >= jkve_pkg::PH_COLON && ph_m <= jkve_pkg::PH_VPLAIN)
                close_value(w, 1'b0);
            w.document_done = 1'b1;
            w.key_found = found_m;
        end
        w.depth_overflow = ovf_m;
        if (eod)
            clear_document();
        return w;
    endfunction

    // Queue a text as document bytes; the last byte carries the end mark when mark_end is set.
    task automatic push_text(string s, bit mark_end);
        for (int i = 0; i < s.len(); i++)
            pending_bytes.push_back('{s[i], (mark_end && i == s.len() - 1)});
    endtask

    function automatic string random_digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(8'(jkve_pkg::CH_ZERO + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string random_word(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(8'($urandom_range(8'h61, 8'h63)))};
        return s;
    endfunction

    // Builds one well-formed or slightly broken document around the key.
    function automatic string random_document(string key);
        string s, v;
        int kind;
        s = "{";
        if ($urandom_range(0, 2) == 0)
            s = {s, "\"", random_word($urandom_range(0, 3)), "\": 1, "};
        kind = $urandom_range(0, 7);
        case (kind)
            0: v = {"\"", random_word($urandom_range(0, 4)), "\""};
            1: v = {"{\"a\":{\"b\":2}", "}"};
            2: v = {"[1,[2,", random_digits(2), "],3]"};
            3: v = {"-", random_digits($urandom_range(1, 12))};
            4: v = {"+", random_digits($urandom_range(1, 4))};
            5: v = random_digits($urandom_range(1, 11));
            6: v = "true";
            default: v = "";
        endcase
        s = {s, "\"", key, "\"", ($urandom_range(0, 1) ? " :\t " : ":"), v};
        if ($urandom_range(0, 5) != 0)
            s = {s, ($urandom_range(0, 1) ? "," : "}"), " \"z\":\"k\"}"};
        return s;
    endfunction

    function automatic string key_text();
        string s;
        s = "";
        for (int i = 0; i < key_len_m && i < jkve_pkg::KEY_MAX; i++)
            s = {s, string'(key_char_at(i[4:0]))};
        return s;
    endfunction

    // Configuration write; the model copy follows the register.
    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            jkve_pkg::REG_KEY_LOW:  key_lo_m = val;
            jkve_pkg::REG_KEY_HIGH: key_hi_m = val;
            jkve_pkg::REG_KEY_LEN:  key_len_m = val[4:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_words.size() != 0 || in_ch.valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Driver: one byte word per handshake with random gaps.
    int gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data_byte <= '0;
            in_ch.end_of_document <= 1'b0;
            gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                expected_words.push_back(extract_predict(
                    '{in_ch.data_byte, in_ch.end_of_document}));
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap > 0)
                begin
                    gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    tb_doc_pkg::doc_byte_t d;
                    d = pending_bytes.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.data_byte <= d.data_byte;
                    in_ch.end_of_document <= d.end_of_document;
                    gap = ($urandom_range(0, 3) == 0)
                        ? (($urandom_range(0, 15) == 0) ? $urandom_range(5, 20)
                                                         : $urandom_range(1, 2)) : 0;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver readiness: random stalls, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_req && !hold_started)
        begin
            hold_started <= 1'b1;
            hold_off <= 60;
            out_ch.ready <= 1'b0;
        end
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(0, 4) != 0)
                || ($urandom_range(0, 40) == 0 ? 1'b0 : ($urandom_range(0, 1) == 1));
    end

    // Monitor: compare each result word with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            tb_doc_pkg::extract_word_t e, a;
            a = '{out_ch.value_valid, out_ch.value_byte, out_ch.value_end,
                  out_ch.value_closed, out_ch.int_value, out_ch.document_done,
                  out_ch.key_found, out_ch.depth_overflow};
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h", $time, a);
                errors++;
            end
            else
            begin
                e = expected_words.pop_front();
                words_checked++;
                if (a.document_done)
                    docs_seen++;
                if (a.value_end)
                    values_seen++;
                if (a !== e)
                begin
                    $display("%0t: mismatch expected vv=%b b=%h end=%b cl=%b int=%0d dd=%b kf=%b ov=%b",
                        $time, e.value_valid, e.value_byte, e.value_end, e.value_closed,
                        $signed(e.int_value), e.document_done, e.key_found,
                        e.depth_overflow);
                    $display("%0t: mismatch actual   vv=%b b=%h end=%b cl=%b int=%0d dd=%b kf=%b ov=%b",
                        $time, a.value_valid, a.value_byte, a.value_end, a.value_closed,
                        $signed(a.int_value), a.document_done, a.key_found,
                        a.depth_overflow);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic random_phase(int n_items);
        int start;
        start = pending_bytes.size();
        while (pending_bytes.size() - start < n_items)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    // Noise bytes of any nonzero value, ended by a byte of any value that carries the end mark.
                    for (int i = $urandom_range(1, 8); i > 0; i--)
                        pending_bytes.push_back('{8'($urandom_range(1, 255)), 1'b0});
                    pending_bytes.push_back('{8'($urandom_range(0, 255)), 1'b1});
                end
                default:
                    push_text(random_document(key_text()), $urandom_range(0, 3) != 0);
            endcase
            if (pending_bytes[$].end_of_document == 1'b0 && pending_bytes[$].data_byte != 0)
                pending_bytes.push_back('{8'd0, 1'b0});
        end
    endtask

    initial
    begin
        string deep;
        key_lo_m = '0;
        key_hi_m = '0;
        key_len_m = '0;
        clear_document();
        cfg.valid = 1'b0;
        cfg.index = jkve_pkg::REG_KEY_LOW;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty key against an empty string key.
        push_text("{\"\":\"v\"}", 1'b1);
        wait_drained();

        // Sixteen-character key: string, saturating integers, overflowed nesting, open string, bare key.
        write_reg(jkve_pkg::REG_KEY_LOW, 64'h6867_6665_6463_6261);
        write_reg(jkve_pkg::REG_KEY_HIGH, 64'h706F_6E6D_6C6B_6A69);
        write_reg(jkve_pkg::REG_KEY_LEN, 64'd16);
        push_text("{\"abcdefghijklmnop\": \"x\\y\"}", 1'b1);
        push_text("{\"abcdefghijklmnop\":-99999999999,}", 1'b1);
        push_text("{\"abcdefghijklmnop\":99999999999}", 1'b1);
        deep = "{\"abcdefghijklmnop\":";
        for (int i = 0; i < 260; i++)
            deep = {deep, "["};
        for (int i = 0; i < 260; i++)
            deep = {deep, "]"};
        push_text(deep, 1'b1);
        push_text("{\"abcdefghijklmnop\":\"open", 1'b1);
        push_text("{\"abcdefghijklmnop\"", 1'b1);
        pending_bytes.push_back('{8'hFF, 1'b0});
        pending_bytes.push_back('{8'h00, 1'b1});
        wait_drained();

        // Over-long key never matches; all-ones registers.
        write_reg(jkve_pkg::REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(jkve_pkg::REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(jkve_pkg::REG_KEY_LEN, 64'd31);
        push_text("{\"a\":1}", 1'b1);
        // Long receiver hold-off while the sender keeps offering.
        hold_req = 1'b1;
        random_phase(40);
        wait_drained();

        // Random phases over several short keys.
        for (int k = 0; k < 4; k++)
        begin
            write_reg(jkve_pkg::REG_KEY_LOW, {$urandom, $urandom} & 64'h0 |
                      {8'h63, 8'h62, 8'h61, 8'h63, 8'h62, 8'h61, 8'h62, 8'h61});
            write_reg(jkve_pkg::REG_KEY_HIGH, {$urandom, $urandom});
            write_reg(jkve_pkg::REG_KEY_LEN, 64'($urandom_range(0, 8)));
            random_phase(70);
            wait_drained();
        end

        $display("Checked %0d result words over %0d documents, %0d values extracted.",
                 words_checked, docs_seen, values_seen);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
